// File: rtl/mdt_pkg.sv
// Shared types, constants and helper functions of the city-block distance engine.
// Depends on nothing; the interfaces, the sweep and the top level refer to it by scoped names.
`default_nettype none

package mdt_pkg;

   // Grid geometry. The request fields carry 7-bit coordinates, so the grid is 128 square.
   localparam int GRID_SIZE  = 128;
   localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
   localparam int IDX_BITS   = $clog2(CELL_COUNT);
   localparam int COORD_BITS = 7;
   localparam int DIST_BITS  = 9;

   // Distances saturate at twice the grid size, held to what nine bits can show.
   localparam int DIST_CAP_INT = ((2 * GRID_SIZE) > 511) ? 511 : (2 * GRID_SIZE);

   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [DIST_BITS-1:0]  dist_type;

   localparam dist_type DIST_CAP        = DIST_BITS'(DIST_CAP_INT);
   localparam dist_type THICKNESS_RESET = DIST_BITS'(4);
   localparam idx_type  LAST_CELL       = IDX_BITS'(CELL_COUNT - 1);
   localparam idx_type  ROW_STRIDE      = IDX_BITS'(GRID_SIZE);
   localparam idx_type  LAST_ROW_START  = IDX_BITS'(CELL_COUNT - GRID_SIZE);
   localparam idx_type  LAST_COL        = IDX_BITS'(GRID_SIZE - 1);

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_RUN   = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   // One cycle's worth of access to the distance memory.
   typedef struct packed {
      logic     we;
      idx_type  waddr;
      dist_type wdata;
      logic     re;
      idx_type  raddr_a;
      idx_type  raddr_b;
   } ram_cmd_type;

   typedef struct packed {
      logic start;
   } sweep_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sweep_sts_type;

   function automatic dist_type min_plus_one(input dist_type cur, input dist_type nb);
      logic [DIST_BITS:0] cand;
      cand = {1'b0, nb} + (DIST_BITS + 1)'(1);
      return (cand < {1'b0, cur}) ? cand[DIST_BITS-1:0] : cur;
   endfunction

   function automatic logic in_grid(input coord_type row, input coord_type col);
      return (int'(row) < GRID_SIZE) && (int'(col) < GRID_SIZE);
   endfunction

   function automatic idx_type cell_index(input coord_type row, input coord_type col);
      return IDX_BITS'(int'(row) * GRID_SIZE + int'(col));
   endfunction

endpackage

`default_nettype wire

// File: rtl/mdt_if.sv
// Handshake channel interfaces: request, response and register write.
// Depends on mdt_pkg for the field types.
`default_nettype none

interface mdt_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   mdt_pkg::coord_type  row;
   mdt_pkg::coord_type  col;
   logic                occupied;

   modport source (output valid, kind, row, col, occupied, input ready);
   modport sink   (input valid, kind, row, col, occupied, output ready);
endinterface

interface mdt_rsp_if;
   logic                valid;
   logic                ready;
   mdt_pkg::coord_type  out_row;
   mdt_pkg::coord_type  out_col;
   mdt_pkg::dist_type   distance;
   logic                inside_res;
   logic                done_res;

   modport source (output valid, out_row, out_col, distance, inside_res, done_res,
                   input ready);
   modport sink   (input valid, out_row, out_col, distance, inside_res, done_res,
                   output ready);
endinterface

interface mdt_csr_if;
   logic                valid;
   logic                ready;
   mdt_pkg::dist_type   thickness;

   modport source (output valid, thickness, input ready);
   modport sink   (input valid, thickness, output ready);
endinterface

`default_nettype wire

// File: rtl/mdt_ram.sv
// Generic synchronous RAM: one write port, two read ports with registered data.
// Stands alone; used for the distance store.
`default_nettype none

module mdt_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 16384
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [$clog2(DEPTH)-1:0]   waddr,
   input  wire logic [WIDTH-1:0]           wdata,
   input  wire logic                       re,
   input  wire logic [$clog2(DEPTH)-1:0]   raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0]   raddr_b,
   output logic      [WIDTH-1:0]           rdata_a,
   output logic      [WIDTH-1:0]           rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

// File: rtl/mdt_sweep.sv
// Two-pass raster sweep over the distance store: forward then backward relaxation.
// Depends on mdt_pkg; drives the memory through a ram_cmd_type while busy.
`default_nettype none

module mdt_sweep (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mdt_pkg::sweep_ctl_type ctl,
   output mdt_pkg::sweep_sts_type      sts,
   output mdt_pkg::ram_cmd_type        cmd,
   input  wire mdt_pkg::dist_type      rdata_a,
   input  wire mdt_pkg::dist_type      rdata_b
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FWD,
      S_GAP,
      S_BWD,
      S_DRAIN
   } state_type;

   state_type         state_ff, state_in;
   mdt_pkg::idx_type  idx_ff, idx_in;
   logic              v1_ff, v1_in;
   logic              fwd1_ff, fwd1_in;
   mdt_pkg::idx_type  idx1_ff, idx1_in;
   mdt_pkg::dist_type prev_ff, prev_in;

   logic              issue;
   mdt_pkg::idx_type  col1;
   logic              use_vert;
   logic              use_horz;
   mdt_pkg::dist_type cell_val;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               state_in = S_FWD;
               idx_in   = '0;
            end
         end
         S_FWD: begin
            if (idx_ff == mdt_pkg::LAST_CELL) begin
               state_in = S_GAP;
            end else begin
               idx_in = idx_ff + mdt_pkg::IDX_BITS'(1);
            end
         end
         S_GAP: begin
            // The last forward write lands here; the backward pass starts after it.
            state_in = S_BWD;
            idx_in   = mdt_pkg::LAST_CELL;
         end
         S_BWD: begin
            if (idx_ff == '0) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff - mdt_pkg::IDX_BITS'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Issue stage: read the cell and its vertical neighbor; the horizontal neighbor
   // is the value computed for the previous cell and kept in prev_ff.
   assign issue   = (state_ff == S_FWD) || (state_ff == S_BWD);
   assign v1_in   = issue;
   assign fwd1_in = (state_ff == S_FWD);
   assign idx1_in = idx_ff;

   assign col1 = idx1_ff & mdt_pkg::LAST_COL;

   always_comb begin
      if (fwd1_ff) begin
         use_vert = (idx1_ff >= mdt_pkg::ROW_STRIDE);
         use_horz = (col1 != '0);
         cell_val = (rdata_a == mdt_pkg::dist_type'(1)) ? '0 : mdt_pkg::DIST_CAP;
         if (rdata_a != mdt_pkg::dist_type'(1)) begin
            if (use_vert) begin
               cell_val = mdt_pkg::min_plus_one(cell_val, rdata_b);
            end
            if (use_horz) begin
               cell_val = mdt_pkg::min_plus_one(cell_val, prev_ff);
            end
         end
      end else begin
         use_vert = (idx1_ff < mdt_pkg::LAST_ROW_START);
         use_horz = (col1 != mdt_pkg::LAST_COL);
         cell_val = rdata_a;
         if (use_vert) begin
            cell_val = mdt_pkg::min_plus_one(cell_val, rdata_b);
         end
         if (use_horz) begin
            cell_val = mdt_pkg::min_plus_one(cell_val, prev_ff);
         end
      end
   end

   assign prev_in = v1_ff ? cell_val : prev_ff;

   always_comb begin
      cmd.we      = v1_ff;
      cmd.waddr   = idx1_ff;
      cmd.wdata   = cell_val;
      cmd.re      = issue;
      cmd.raddr_a = idx_ff;
      cmd.raddr_b = (state_ff == S_FWD) ? (idx_ff - mdt_pkg::ROW_STRIDE)
                                        : (idx_ff + mdt_pkg::ROW_STRIDE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         v1_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= v1_in;
      end
      idx_ff  <= idx_in;
      fwd1_ff <= fwd1_in;
      idx1_ff <= idx1_in;
      prev_ff <= prev_in;
   end

   assign sts.busy = (state_ff != S_IDLE);
   assign sts.done = (state_ff == S_DRAIN);

endmodule

`default_nettype wire

// File: rtl/manhattan_distance_thicken.sv
// Top level of the city-block distance engine: request decode, reply register, thickness.
// Depends on mdt_pkg, the interfaces in mdt_if, mdt_ram and mdt_sweep.
//
//   channel    direction  beat carries                                    handshake
//   req_chan   in         kind, row, col, occupied                        valid/ready
//   rsp_chan   out        out_row, out_col, distance, inside_res, done_res valid/ready
//   csr_chan   in         thickness                                       valid/ready
//
// A write beat goes straight into the memory and a read beat answers through the
// registered read data and the reply register, both limited by the single read/write
// port pair of the distance memory. A run beat walks the grid twice through the memory
// at one cell per cycle and answers with a done reply once the sweep ends; no request is taken meanwhile.
// Reset is synchronous and clears the control state and sets thickness to 4; the
// distance memory keeps its contents and needs no clearing pass.
// A stalled reply blocks new requests until it is taken; the register port is
// always ready.
`default_nettype none

module manhattan_distance_thicken (
   input  wire logic  clock,
   input  wire logic  reset,
   mdt_req_if.sink    req_chan,
   mdt_rsp_if.source  rsp_chan,
   mdt_csr_if.sink    csr_chan
);

   // Sweep engine and memory.
   mdt_pkg::sweep_ctl_type sweep_ctl;
   mdt_pkg::sweep_sts_type sweep_sts;
   mdt_pkg::ram_cmd_type   sweep_cmd;
   mdt_pkg::ram_cmd_type   host_cmd;
   mdt_pkg::ram_cmd_type   ram_cmd;
   mdt_pkg::dist_type      rdata_a;
   mdt_pkg::dist_type      rdata_b;

   // Request side.
   logic                   req_accept;
   logic                   is_write;
   logic                   is_run;
   logic                   is_read;
   logic                   req_in_grid;
   mdt_pkg::idx_type       req_idx;

   // Read in flight: the memory data shows up the cycle after the beat is taken.
   logic                   rd_pend_ff, rd_pend_in;
   mdt_pkg::coord_type     rd_row_ff;
   mdt_pkg::coord_type     rd_col_ff;
   logic                   rd_in_grid_ff;
   mdt_pkg::dist_type      rd_dist;

   // Reply register.
   logic                   rsp_valid_ff, rsp_valid_in;
   mdt_pkg::coord_type     rsp_row_ff, rsp_row_in;
   mdt_pkg::coord_type     rsp_col_ff, rsp_col_in;
   mdt_pkg::dist_type      rsp_dist_ff, rsp_dist_in;
   logic                   rsp_inside_ff, rsp_inside_in;
   logic                   rsp_done_ff, rsp_done_in;

   mdt_pkg::dist_type      thickness_ff, thickness_in;

   // A new beat is taken only when the memory is ours, no read is in flight, and
   // the reply register is empty or being emptied in this cycle.
   assign req_chan.ready = !sweep_sts.busy && !rd_pend_ff
                         && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign is_write    = req_accept && (req_chan.kind == mdt_pkg::KIND_WRITE);
   assign is_run      = req_accept && (req_chan.kind == mdt_pkg::KIND_RUN);
   assign is_read     = req_accept && (req_chan.kind == mdt_pkg::KIND_READ);
   assign req_in_grid = mdt_pkg::in_grid(req_chan.row, req_chan.col);
   assign req_idx     = mdt_pkg::cell_index(req_chan.row, req_chan.col);

   assign sweep_ctl.start = is_run;

   always_comb begin
      host_cmd.we      = is_write && req_in_grid;
      host_cmd.waddr   = req_idx;
      host_cmd.wdata   = mdt_pkg::DIST_BITS'(req_chan.occupied);
      host_cmd.re      = is_read;
      host_cmd.raddr_a = req_idx;
      host_cmd.raddr_b = req_idx;
   end

   // The sweep owns the memory for the whole run.
   assign ram_cmd = sweep_sts.busy ? sweep_cmd : host_cmd;

   mdt_ram #(
      .WIDTH (mdt_pkg::DIST_BITS),
      .DEPTH (mdt_pkg::CELL_COUNT)
   ) u_store (
      .clock   (clock),
      .we      (ram_cmd.we),
      .waddr   (ram_cmd.waddr),
      .wdata   (ram_cmd.wdata),
      .re      (ram_cmd.re),
      .raddr_a (ram_cmd.raddr_a),
      .raddr_b (ram_cmd.raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   mdt_sweep u_sweep (
      .clock   (clock),
      .reset   (reset),
      .ctl     (sweep_ctl),
      .sts     (sweep_sts),
      .cmd     (sweep_cmd),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   assign rd_pend_in = is_read;

   // A cell off the grid answers with the cap and is never inside.
   assign rd_dist = rd_in_grid_ff ? rdata_a : mdt_pkg::DIST_CAP;

   // The reply register is always free when a read completes or a run finishes,
   // because both were only accepted with room for their reply.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_done_in   = rsp_done_ff;
      priority if (sweep_sts.done) begin
         rsp_valid_in  = 1'b1;
         rsp_row_in    = '0;
         rsp_col_in    = '0;
         rsp_dist_in   = '0;
         rsp_inside_in = 1'b0;
         rsp_done_in   = 1'b1;
      end else if (rd_pend_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_row_in    = rd_row_ff;
         rsp_col_in    = rd_col_ff;
         rsp_dist_in   = rd_dist;
         rsp_inside_in = rd_in_grid_ff && (rd_dist <= thickness_ff);
         rsp_done_in   = 1'b0;
      end
   end

   // Register writes must only be issued while the engine is idle; the block has no guard and does not enforce it.
   assign csr_chan.ready = 1'b1;
   assign thickness_in   = csr_chan.valid ? csr_chan.thickness : thickness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thickness_ff <= mdt_pkg::THICKNESS_RESET;
      end else begin
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         thickness_ff <= thickness_in;
      end
      if (is_read) begin
         rd_row_ff     <= req_chan.row;
         rd_col_ff     <= req_chan.col;
         rd_in_grid_ff <= req_in_grid;
      end
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_row    = rsp_row_ff;
   assign rsp_chan.out_col    = rsp_col_ff;
   assign rsp_chan.distance   = rsp_dist_ff;
   assign rsp_chan.inside_res = rsp_inside_ff;
   assign rsp_chan.done_res   = rsp_done_ff;

endmodule

`default_nettype wire
